/* hdl/olst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_pkg: shared definitions for the ordered list engine
// Sizes, request and status codes, and the structs passed between the
// cell chain, the scan tree and the top level.
// ----------------------------------------------------------------------------
package olst_pkg;

    // List geometry. DEPTH is a power of two and at least 32.
    localparam int DEPTH   = 256;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;

    // Scan tree: first level groups of GROUP cells, second level over groups.
    localparam int GROUP   = 16;
    localparam int GRP_W   = $clog2(GROUP);
    localparam int NGRP    = DEPTH / GROUP;

    // Transaction field widths.
    localparam int KIND_W      = 3;
    localparam int POS_W       = 8;
    localparam int ST_W        = 3;
    localparam int FIDX_W      = 8;
    localparam int ECNT_W      = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // Width used for index range checks; covers both position and count.
    localparam int CMP_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_MODIFY = 3'd2,
        KIND_FIND   = 3'd3,
        KIND_READ   = 3'd4,
        KIND_PUSH   = 3'd5,
        KIND_POP    = 3'd6
    } kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_WR   = 2'd3
    } cell_op_t;

    // Broadcast control seen by every cell of the chain.
    typedef struct packed {
        cell_op_t            op;
        logic                find;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   value;
        logic [CNT_W-1:0]    count;
    } cell_ctrl_t;

    // Result of the first-hit scan over the chain.
    typedef struct packed {
        logic                hit;
        logic [IDX_W-1:0]    index;
        logic [DATA_W-1:0]   value;
    } scan_res_t;

endpackage

/* hdl/olst_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the list chain
// Holds one entry, shifts it to or from its neighbors on insert and erase,
// and flags whether it matches the current lookup.
// ----------------------------------------------------------------------------
module olst_cell (
    input  logic                       clk,
    input  olst_pkg::cell_ctrl_t       ctrl,
    input  logic [olst_pkg::IDX_W-1:0] cell_idx,
    input  logic [olst_pkg::DATA_W-1:0] lower_value,
    input  logic [olst_pkg::DATA_W-1:0] upper_value,
    output logic [olst_pkg::DATA_W-1:0] value,
    output logic                       hit
);
    import olst_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              live;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_INS:
            begin
                if (cell_idx > ctrl.idx)
                begin
                    value_next = lower_value;
                end
                else if (cell_idx == ctrl.idx)
                begin
                    value_next = ctrl.value;
                end
            end
            CELL_DEL:
            begin
                if (cell_idx >= ctrl.idx)
                begin
                    value_next = upper_value;
                end
            end
            CELL_WR:
            begin
                if (cell_idx == ctrl.idx)
                begin
                    value_next = ctrl.value;
                end
            end
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Only entries below the count take part in a lookup.
    assign live  = ({1'b0, cell_idx} < ctrl.count);
    assign hit   = live && (ctrl.find ? (value_reg == ctrl.value) : (cell_idx == ctrl.idx));
    assign value = value_reg;

endmodule

/* hdl/olst_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_scan: two-level registered first-hit tree over the cell chain
// Picks the lowest cell that flags a hit and returns its index and value
// through the group registers and then the result register.
// ----------------------------------------------------------------------------
module olst_scan (
    input  logic                        clk,
    input  logic                        hit [olst_pkg::DEPTH],
    input  logic [olst_pkg::DATA_W-1:0] value [olst_pkg::DEPTH],
    output olst_pkg::scan_res_t         result
);
    import olst_pkg::*;

    logic              grp_hit_reg [NGRP];
    logic [GRP_W-1:0]  grp_idx_reg [NGRP];
    logic [DATA_W-1:0] grp_val_reg [NGRP];
    scan_res_t         result_reg;
    scan_res_t         result_next;

    genvar g;
    generate
        for (g = 0; g < NGRP; g++)
        begin : gen_grp
            logic              hit_c;
            logic [GRP_W-1:0]  idx_c;
            logic [DATA_W-1:0] val_c;

            // Walk from the top so that the lowest hit wins.
            always_comb
            begin
                hit_c = 1'b0;
                idx_c = '0;
                val_c = '0;
                for (int j = GROUP - 1; j >= 0; j--)
                begin
                    if (hit[g * GROUP + j])
                    begin
                        hit_c = 1'b1;
                        idx_c = GRP_W'(j);
                        val_c = value[g * GROUP + j];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                grp_hit_reg[g] <= hit_c;
                grp_idx_reg[g] <= idx_c;
                grp_val_reg[g] <= val_c;
            end
        end
    endgenerate

    always_comb
    begin
        result_next = '0;
        for (int k = NGRP - 1; k >= 0; k--)
        begin
            if (grp_hit_reg[k])
            begin
                result_next.hit   = 1'b1;
                result_next.index = (IDX_W'(k) << GRP_W) | IDX_W'(grp_idx_reg[k]);
                result_next.value = grp_val_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* hdl/ordered_list_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_unit: ordered list of signed entries held in a cell chain
// Insert, erase, overwrite, find, read, push back and pop back on a list of
// up to DEPTH entries, one result transaction per request transaction.
// ----------------------------------------------------------------------------
// Sequencing: a request is accepted in the idle state, then passes the two
// registered levels of the first-hit scan tree and the finishing step; no new
// request is taken until that finishing step is done.
// A waiting result in the output register delays only the finishing step.
// Reset clears the entry count, the sequencer and the output valid; entry
// contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request: kind[2:0], position[10:3], item_value[42:11], zero pad above.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [olst_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result: status[2:0], found_index[10:3], read_value[42:11],
    // entry_count[51:43], zero pad above.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [olst_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import olst_pkg::*;

    // Sequencer: accept, two scan states, then finish (mutate and respond).
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN1 = 4'b0010,
        S_SCAN2 = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Latched request.
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] val_reg;
    status_t           status_reg;

    logic [IDX_W-1:0]  idx_next;
    status_t           status_next;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    logic              accept;
    logic              fin_fire;

    // Request fields.
    logic [KIND_W-1:0] in_kind;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;

    cell_ctrl_t        cell_ctrl;
    logic [DATA_W-1:0] cell_value [DEPTH];
    logic              cell_hit   [DEPTH];
    scan_res_t         scan_res;

    status_t           out_status;
    logic [IDX_W-1:0]  out_index;
    logic [DATA_W-1:0] out_value;
    logic              req_ok;

    assign in_kind  = s_tdata[2:0];
    assign in_pos   = s_tdata[10:3];
    assign in_value = s_tdata[42:11];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_fire = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    assign req_ok   = (status_reg == ST_OK);

    // Every error except a missed search is known from the position and count, so it
    // is settled when the request is taken.
    assign pos_c = CMP_W'(in_pos);
    assign cnt_c = CMP_W'(count_reg);

    always_comb
    begin
        status_next = ST_OK;
        idx_next    = IDX_W'(in_pos);
        unique case (in_kind)
            KIND_INSERT:
            begin
                if (pos_c > cnt_c)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (cnt_c >= CMP_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
            end
            KIND_ERASE, KIND_MODIFY, KIND_READ:
            begin
                if (pos_c >= cnt_c)
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            KIND_PUSH:
            begin
                idx_next = IDX_W'(count_reg);
                if (cnt_c >= CMP_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
            end
            KIND_POP:
            begin
                idx_next = IDX_W'(count_reg - CNT_W'(1));
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= in_kind;
            idx_reg    <= idx_next;
            val_reg    <= in_value;
            status_reg <= status_next;
        end
    end

    // The chain only changes on the finishing edge, so the scan sees a stable
    // list for the whole request.
    always_comb
    begin
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.find  = (kind_reg == KIND_FIND);
        cell_ctrl.idx   = idx_reg;
        cell_ctrl.value = val_reg;
        cell_ctrl.count = count_reg;
        if (fin_fire && req_ok)
        begin
            unique case (kind_reg)
                KIND_INSERT, KIND_PUSH: cell_ctrl.op = CELL_INS;
                KIND_ERASE, KIND_POP:   cell_ctrl.op = CELL_DEL;
                KIND_MODIFY:            cell_ctrl.op = CELL_WR;
                default:                cell_ctrl.op = CELL_HOLD;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : gen_cell
            logic [DATA_W-1:0] lower_v;
            logic [DATA_W-1:0] upper_v;

            if (i == 0)
            begin : gen_bottom
                assign lower_v = '0;
            end
            else
            begin : gen_lower
                assign lower_v = cell_value[i-1];
            end

            if (i == DEPTH - 1)
            begin : gen_top
                assign upper_v = '0;
            end
            else
            begin : gen_upper
                assign upper_v = cell_value[i+1];
            end

            olst_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .cell_idx    (IDX_W'(i)),
                .lower_value (lower_v),
                .upper_value (upper_v),
                .value       (cell_value[i]),
                .hit         (cell_hit[i])
            );
        end
    endgenerate

    olst_scan u_scan (
        .clk    (clk),
        .hit    (cell_hit),
        .value  (cell_value),
        .result (scan_res)
    );

    // Result assembly on the finishing cycle.
    always_comb
    begin
        out_status = status_reg;
        out_index  = '0;
        out_value  = '0;
        count_next = count_reg;
        unique case (kind_reg)
            KIND_FIND:
            begin
                if (scan_res.hit)
                begin
                    out_index = scan_res.index;
                end
                else
                begin
                    out_status = ST_NOT_FOUND;
                end
            end
            KIND_INSERT, KIND_PUSH:
            begin
                if (req_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_ERASE, KIND_POP:
            begin
                if (req_ok)
                begin
                    out_value  = scan_res.value;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (req_ok)
                begin
                    out_value = scan_res.value;
                end
            end
            default:
            begin
                out_status = status_reg;
            end
        endcase
    end

    always_comb
    begin
        m_tdata_next        = '0;
        m_tdata_next[2:0]   = out_status;
        m_tdata_next[10:3]  = FIDX_W'(out_index);
        m_tdata_next[42:11] = out_value;
        m_tdata_next[51:43] = ECNT_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_SCAN1;
            S_SCAN1: state_next = S_SCAN2;
            S_SCAN2: state_next = S_FIN;
            S_FIN:   if (fin_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_fire)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The count never exceeds the list capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // The chain is only modified on the finishing edge of a request.
    a_mutate_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.op != CELL_HOLD) |-> fin_fire)
        else $error("cell chain modified outside the finishing cycle");

    // The count moves by at most one, and only when a request finishes.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> (count_reg == $past(count_reg))
                  || (count_reg == $past(count_reg) + CNT_W'(1))
                  || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fin_fire |=> $stable(count_reg))
        else $error("entry count changed without a finishing request");

    // A missed search always reports index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == ST_NOT_FOUND)) |-> (m_tdata[10:3] == '0))
        else $error("missed search with nonzero index");
`endif

endmodule
